FILE: design/assert_macros.svh
// Assertion macros shared by the ray/segment intersection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RSI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check a property on every rising clock edge, including while reset is applied.
`define RSI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: design/rsi_pkg.sv
// Package: widths, transaction types and CORDIC constants for ray/segment intersection.
package rsi_pkg;

    localparam int COORD_BITS      = 24;
    localparam int ANGLE_BITS      = 16;
    localparam int TRIG_ITERATIONS = 16;
    localparam int TRIG_FRAC       = 30;

    localparam int CW  = COORD_BITS;          // coordinate width
    localparam int RW  = COORD_BITS - 1;      // radius and distance width
    localparam int DW  = COORD_BITS + 1;      // coordinate differences, ray vector
    localparam int PW  = 2 * DW + 1;          // cross product differences
    localparam int TW  = TRIG_FRAC + 3;       // CORDIC x and y
    localparam int ZW  = 32;                  // CORDIC angle accumulator
    localparam int MW  = RW + 1 + TW;         // radius times trig
    localparam int RMW = PW + 2;              // divider partial remainder

    localparam logic signed [TW-1:0] TRIG_GAIN = TW'(652032874);

    localparam logic signed [ZW-1:0] ATAN_TURNS [24] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    typedef struct packed {
        logic signed [CW-1:0]  origin_x;
        logic signed [CW-1:0]  origin_y;
        logic [ANGLE_BITS-1:0] ray_angle;
        logic [RW-1:0]         ray_length;
        logic signed [CW-1:0]  seg_start_x;
        logic signed [CW-1:0]  seg_start_y;
        logic signed [CW-1:0]  seg_end_x;
        logic signed [CW-1:0]  seg_end_y;
    } in_t;

    typedef struct packed {
        logic          hit;
        logic [RW-1:0] distance;
    } out_t;

    // CORDIC rotation state
    typedef struct packed {
        logic signed [TW-1:0] x;
        logic signed [TW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [1:0]           quad;
    } cs_t;

    // Direction cosine and sine in Q2.30
    typedef struct packed {
        logic signed [TW-1:0] cv;
        logic signed [TW-1:0] sv;
    } trig_t;

    // Divider work handed over by the cross product unit
    typedef struct packed {
        logic          hit;
        logic [PW-1:0] den;
        logic [PW-1:0] na;
        logic [RW-1:0] radius;
    } div_t;

endpackage

FILE: design/ray_segment_intersection_distance_top.sv
// Top level: ray against segment intersection distance pipeline.
//
// Usage:
//   Input channel s_valid/s_ready/s_payload carries one ray (origin, angle,
//   length) and one segment (two endpoints) per transaction, in Q15.8.
//   Output channel m_valid/m_ready/m_payload returns one transaction per
//   input: hit, and the distance to the hit (zero when there is none).
//   Results leave in input order.
// Timing:
//   The pipeline has 16 CORDIC iterations, a quadrant fold, 5 stages of
//   scaling and cross products and 23 long division steps, one per radius bit.
//   Throughput is one transaction per cycle while the output is not stalled;
//   the division stages set the depth.
// Reset:
//   aresetn is synchronous and active low; it empties the pipeline and the
//   output goes invalid. There is no other state.
// Back-pressure:
//   While m_valid is high and m_ready low the whole pipeline holds and
//   s_ready drops; nothing is lost or repeated.
module ray_segment_intersection_distance_top
    import rsi_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_payload,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_payload
);

    `include "assert_macros.svh"

    logic  en;
    logic  trig_vld;
    in_t   trig_data;
    trig_t trig;
    logic  work_vld;
    div_t  work;

    // Advance every stage unless a finished result is held at the output
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    rsi_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_payload),
        .out_valid (trig_vld),
        .out_data  (trig_data),
        .out_trig  (trig)
    );

    rsi_cross u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (trig_vld),
        .in_data   (trig_data),
        .in_trig   (trig),
        .out_valid (work_vld),
        .out_work  (work)
    );

    rsi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (work_vld),
        .in_work   (work),
        .out_valid (m_valid),
        .out_data  (m_payload)
    );

    `RSI_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_valid,
        "output valid straight after reset")

endmodule

FILE: design/rsi_cordic.sv
// Pipelined rotation CORDIC: one iteration per stage, then quadrant fold.
module rsi_cordic
    import rsi_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  in_t   in_data,
    output logic  out_valid,
    output in_t   out_data,
    output trig_t out_trig
);

    `include "assert_macros.svh"

    localparam int N = TRIG_ITERATIONS;

    logic [31:0] a32;
    cs_t         init;

    cs_t         st_reg [N];
    in_t         pl_reg [N];
    logic [N-1:0] vld_reg;

    trig_t       trig_reg;
    in_t         opl_reg;
    logic        ovld_reg;

    // Widen the angle to 32 bits of a turn, split quadrant and fraction
    always_comb begin
        a32       = 32'(in_data.ray_angle) << (32 - ANGLE_BITS);
        init.x    = TRIG_GAIN;
        init.y    = '0;
        init.z    = ZW'(a32[29:0]);
        init.quad = a32[31:30];
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        cs_t  src;
        cs_t  nxt;
        in_t  src_pl;
        logic src_vld;

        if (i == 0) begin : g_first
            assign src     = init;
            assign src_pl  = in_data;
            assign src_vld = in_valid;
        end else begin : g_rest
            assign src     = st_reg[i-1];
            assign src_pl  = pl_reg[i-1];
            assign src_vld = vld_reg[i-1];
        end

        // Rotate towards zero residual angle
        always_comb begin
            nxt.quad = src.quad;
            if (!src.z[ZW-1]) begin
                nxt.x = src.x - (src.y >>> i);
                nxt.y = src.y + (src.x >>> i);
                nxt.z = src.z - ATAN_TURNS[i];
            end else begin
                nxt.x = src.x + (src.y >>> i);
                nxt.y = src.y - (src.x >>> i);
                nxt.z = src.z + ATAN_TURNS[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= src_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[i] <= nxt;
                pl_reg[i] <= src_pl;
            end
        end
    end

    // Fold the result back into its quadrant
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovld_reg <= 1'b0;
        end else if (en) begin
            ovld_reg <= vld_reg[N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            opl_reg <= pl_reg[N-1];
            case (st_reg[N-1].quad)
                2'd0: begin
                    trig_reg.cv <= st_reg[N-1].x;
                    trig_reg.sv <= st_reg[N-1].y;
                end
                2'd1: begin
                    trig_reg.cv <= -st_reg[N-1].y;
                    trig_reg.sv <= st_reg[N-1].x;
                end
                2'd2: begin
                    trig_reg.cv <= -st_reg[N-1].x;
                    trig_reg.sv <= -st_reg[N-1].y;
                end
                default: begin
                    trig_reg.cv <= st_reg[N-1].y;
                    trig_reg.sv <= -st_reg[N-1].x;
                end
            endcase
        end
    end

    assign out_valid = ovld_reg;
    assign out_data  = opl_reg;
    assign out_trig  = trig_reg;

    `RSI_ASSERT(a_trig_bounded,
        ovld_reg |-> (trig_reg.cv[TW-1] == trig_reg.cv[TW-2])
                  && (trig_reg.sv[TW-1] == trig_reg.sv[TW-2]),
        "cordic output out of range")

endmodule

FILE: design/rsi_cross.sv
// Ray vector scaling, cross products, sign fold and range test.
module rsi_cross
    import rsi_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  in_t   in_data,
    input  trig_t in_trig,
    output logic  out_valid,
    output div_t  out_work
);

    `include "assert_macros.svh"

    localparam logic signed [MW-1:0] HALF = MW'(1) << (TRIG_FRAC - 1);

    logic [4:0] vld_reg;

    // stage A
    logic signed [MW-1:0] pc_reg, ps_reg;
    logic signed [DW-1:0] ex_a_reg, ey_a_reg, wx_a_reg, wy_a_reg;
    logic [RW-1:0]        rad_a_reg;
    // stage B
    logic signed [DW-1:0] dxr_reg, dyr_reg;
    logic signed [DW-1:0] ex_b_reg, ey_b_reg, wx_b_reg, wy_b_reg;
    logic [RW-1:0]        rad_b_reg;
    logic signed [MW-1:0] pc_rnd, ps_rnd;
    // stage C
    logic signed [2*DW-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic [RW-1:0]          rad_c_reg;
    // stage D
    logic signed [PW-1:0] den_reg, na_reg, nb_reg;
    logic [RW-1:0]        rad_d_reg;
    // stage E
    logic signed [PW-1:0] den_n, na_n, nb_n;
    logic                 hit_n;
    div_t                 work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // Stage A: scale trig by radius, form segment and origin offsets
    always_ff @(posedge aclk) begin
        if (en) begin
            pc_reg    <= $signed({1'b0, in_data.ray_length}) * in_trig.cv;
            ps_reg    <= $signed({1'b0, in_data.ray_length}) * in_trig.sv;
            ex_a_reg  <= DW'(in_data.seg_end_x) - DW'(in_data.seg_start_x);
            ey_a_reg  <= DW'(in_data.seg_end_y) - DW'(in_data.seg_start_y);
            wx_a_reg  <= DW'(in_data.origin_x) - DW'(in_data.seg_start_x);
            wy_a_reg  <= DW'(in_data.origin_y) - DW'(in_data.seg_start_y);
            rad_a_reg <= in_data.ray_length;
        end
    end

    // Stage B: round half up back to Q15.8
    assign pc_rnd = (pc_reg + HALF) >>> TRIG_FRAC;
    assign ps_rnd = (ps_reg + HALF) >>> TRIG_FRAC;

    always_ff @(posedge aclk) begin
        if (en) begin
            dxr_reg   <= DW'(pc_rnd);
            dyr_reg   <= DW'(ps_rnd);
            ex_b_reg  <= ex_a_reg;
            ey_b_reg  <= ey_a_reg;
            wx_b_reg  <= wx_a_reg;
            wy_b_reg  <= wy_a_reg;
            rad_b_reg <= rad_a_reg;
        end
    end

    // Stage C: the six cross product terms
    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg    <= ey_b_reg * dxr_reg;
            p2_reg    <= ex_b_reg * dyr_reg;
            p3_reg    <= ex_b_reg * wy_b_reg;
            p4_reg    <= ey_b_reg * wx_b_reg;
            p5_reg    <= dxr_reg * wy_b_reg;
            p6_reg    <= dyr_reg * wx_b_reg;
            rad_c_reg <= rad_b_reg;
        end
    end

    // Stage D: denominator and both numerators
    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg   <= PW'(p1_reg) - PW'(p2_reg);
            na_reg    <= PW'(p3_reg) - PW'(p4_reg);
            nb_reg    <= PW'(p5_reg) - PW'(p6_reg);
            rad_d_reg <= rad_c_reg;
        end
    end

    // Stage E: make the denominator positive, test both parameters in [0,1]
    always_comb begin
        if (den_reg[PW-1]) begin
            den_n = -den_reg;
            na_n  = -na_reg;
            nb_n  = -nb_reg;
        end else begin
            den_n = den_reg;
            na_n  = na_reg;
            nb_n  = nb_reg;
        end
        hit_n = (den_reg != '0) && !na_n[PW-1] && (na_n <= den_n)
                && !nb_n[PW-1] && (nb_n <= den_n);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            work_reg.hit    <= hit_n;
            work_reg.den    <= den_n;
            work_reg.na     <= na_n;
            work_reg.radius <= rad_d_reg;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_work  = work_reg;

    `RSI_ASSERT(a_hit_ratio,
        (vld_reg[4] && work_reg.hit) |-> (work_reg.den != '0)
                                      && (work_reg.na <= work_reg.den),
        "hit with numerator above denominator")

endmodule

FILE: design/rsi_div.sv
// Pipelined long division: distance = floor(na * radius / den), one radius bit per stage.
module rsi_div
    import rsi_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  div_t in_work,
    output logic out_valid,
    output out_t out_data
);

    `include "assert_macros.svh"

    logic [RMW-1:0] rem_reg [RW];
    logic [RW-1:0]  q_reg   [RW];
    div_t           wk_reg  [RW];
    logic [RW-1:0]  vld_reg;

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic [RMW-1:0] src_rem;
        logic [RW-1:0]  src_q;
        div_t           src_wk;
        logic           src_vld;
        logic [RMW-1:0] t;
        logic [RMW-1:0] d1;
        logic [RMW-1:0] d2;
        logic [RMW-1:0] nxt_rem;
        logic [RW-1:0]  nxt_q;

        if (k == 0) begin : g_first
            assign src_rem = '0;
            assign src_q   = '0;
            assign src_wk  = in_work;
            assign src_vld = in_valid;
        end else begin : g_rest
            assign src_rem = rem_reg[k-1];
            assign src_q   = q_reg[k-1];
            assign src_wk  = wk_reg[k-1];
            assign src_vld = vld_reg[k-1];
        end

        // Shift in the next radius bit, then take out up to two denominators
        always_comb begin
            d1 = RMW'(src_wk.den);
            d2 = RMW'({src_wk.den, 1'b0});
            t  = {src_rem[RMW-2:0], 1'b0}
                 + (src_wk.radius[RW-1-k] ? RMW'(src_wk.na) : RMW'(0));
            if (t >= d2) begin
                nxt_rem = t - d2;
                nxt_q   = {src_q[RW-2:0], 1'b0} + RW'(2);
            end else if (t >= d1) begin
                nxt_rem = t - d1;
                nxt_q   = {src_q[RW-2:0], 1'b0} + RW'(1);
            end else begin
                nxt_rem = t;
                nxt_q   = {src_q[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= src_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= nxt_rem;
                q_reg[k]   <= nxt_q;
                wk_reg[k]  <= src_wk;
            end
        end
    end

    // Drop the quotient when there is no hit
    assign out_valid         = vld_reg[RW-1];
    assign out_data.hit      = wk_reg[RW-1].hit;
    assign out_data.distance = wk_reg[RW-1].hit ? q_reg[RW-1] : '0;

    `RSI_ASSERT(a_dist_le_radius,
        (vld_reg[RW-1] && wk_reg[RW-1].hit) |-> (q_reg[RW-1] <= wk_reg[RW-1].radius),
        "distance beyond ray length")

endmodule

FILE: tb/tb_ray_segment_intersection_distance_top.sv
// Testbench for the ray/segment intersection distance pipeline, with its scoreboard.
module tb_ray_segment_intersection_distance_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rsi_pkg::*;

    // Scoreboard: predicts hit and distance per ray/segment pair, checks results in order
    class hit_scoreboard;
        out_t pending_hits[$];
        int   fail_count = 0;

        // Arithmetic shift right, rounding toward minus infinity
        function automatic longint shr_floor(longint v, int s);
            return v >>> s;
        endfunction

        function automatic out_t predict_hit(in_t t);
            longint x, y, z, dx, dy, cv, sv, dxr, dyr;
            longint bx, by, s1x, s1y, s2x, s2y, ex, ey, wx, wy, den, na, nb;
            longint radius;
            logic [31:0] a32;
            longint unsigned ud, un, rem, q;
            out_t r;
            r = '0;
            a32 = {t.ray_angle, 16'h0000};
            x = 652032874;
            y = 0;
            z = longint'(a32[29:0]);
            for (int i = 0; i < TRIG_ITERATIONS; i++) begin
                dx = shr_floor(y, i);
                dy = shr_floor(x, i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
                end else begin
                    x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
                end
            end
            case (a32[31:30])
                2'd0: begin cv = x;  sv = y;  end
                2'd1: begin cv = -y; sv = x;  end
                2'd2: begin cv = -x; sv = -y; end
                default: begin cv = y; sv = -x; end
            endcase
            radius = longint'(t.ray_length);
            dxr = shr_floor(radius * cv + (64'sd1 <<< 29), 30);
            dyr = shr_floor(radius * sv + (64'sd1 <<< 29), 30);
            bx = t.origin_x; by = t.origin_y;
            s1x = t.seg_start_x; s1y = t.seg_start_y;
            s2x = t.seg_end_x; s2y = t.seg_end_y;
            ex = s2x - s1x; ey = s2y - s1y;
            wx = bx - s1x;  wy = by - s1y;
            den = ey * dxr - ex * dyr;
            na = ex * wy - ey * wx;
            nb = dxr * wy - dyr * wx;
            if (den != 0) begin
                if (den < 0) begin
                    den = -den; na = -na; nb = -nb;
                end
                if (na >= 0 && na <= den && nb >= 0 && nb <= den) begin
                    ud = den; un = na; rem = 0; q = 0;
                    r.hit = 1'b1;
                    for (int b = RW - 1; b >= 0; b--) begin
                        rem = rem << 1; q = q << 1;
                        if (t.ray_length[b]) rem += un;
                        if (rem >= ud) begin rem -= ud; q++; end
                        if (rem >= ud) begin rem -= ud; q++; end
                    end
                    r.distance = q[RW-1:0];
                end
            end
            return r;
        endfunction

        function void note_input(in_t t);
            pending_hits.push_back(predict_hit(t));
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (pending_hits.size() == 0) begin
                $error("unexpected result: hit=%0d distance=%0d", got.hit, got.distance);
                fail_count++;
                return;
            end
            want = pending_hits.pop_front();
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                fail_count++;
            end
            if (got.distance !== want.distance) begin
                $error("distance: expected %0d, actual %0d", want.distance, got.distance);
                fail_count++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_payload;

    hit_scoreboard board = new();
    bit stimulus_done = 1'b0;
    int stall_mode = 0;

    ray_segment_intersection_distance_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_input(s_payload);
            if (m_valid && m_ready) board.check_result(m_payload);
        end
    end

    // Receiver stalls: phases of always ready, random, and long holds
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return CW'($urandom);
            1: return {1'b0, {(CW-1){1'b1}}};
            2: return {1'b1, {(CW-1){1'b0}}};
            default: return CW'($signed($urandom_range(0, 40000)) - 20000);
        endcase
    endfunction

    // Hand one transaction over and wait for its acceptance
    task automatic send_pair(in_t t);
        s_payload <= t;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_pair_then_gap(in_t t, int gap);
        send_pair(t);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Mostly well-formed rays at random angles near segments close by, some pure noise
    function automatic in_t random_pair();
        in_t t;
        t.ray_angle = 16'($urandom);
        if ($urandom_range(0, 9) < 8) begin
            t.origin_x    = CW'($signed($urandom_range(0, 4000)) - 2000);
            t.origin_y    = CW'($signed($urandom_range(0, 4000)) - 2000);
            t.ray_length  = RW'($urandom_range(0, 8000));
            t.seg_start_x = CW'($signed($urandom_range(0, 8000)) - 4000);
            t.seg_start_y = CW'($signed($urandom_range(0, 8000)) - 4000);
            t.seg_end_x   = CW'($signed($urandom_range(0, 8000)) - 4000);
            t.seg_end_y   = CW'($signed($urandom_range(0, 8000)) - 4000);
            if ($urandom_range(0, 9) == 0) begin
                t.seg_end_x = t.seg_start_x; t.seg_end_y = t.seg_start_y;
            end
        end else begin
            t.origin_x = rand_coord(); t.origin_y = rand_coord();
            t.ray_length = RW'($urandom);
            t.seg_start_x = rand_coord(); t.seg_start_y = rand_coord();
            t.seg_end_x = rand_coord(); t.seg_end_y = rand_coord();
        end
        return t;
    endfunction

    function automatic in_t make_pair(int ox, int oy, int ang, int rad,
                                      int ax, int ay, int bx, int by);
        in_t t;
        t.origin_x = CW'(ox); t.origin_y = CW'(oy);
        t.ray_angle = 16'(ang); t.ray_length = RW'(rad);
        t.seg_start_x = CW'(ax); t.seg_start_y = CW'(ay);
        t.seg_end_x = CW'(bx); t.seg_end_y = CW'(by);
        return t;
    endfunction

    initial begin
        int burst;
        int gap;
        in_t t;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: plain hits, each quadrant, ends of ray and segment
        send_pair(make_pair(0, 0, 0, 2560, 1280, -512, 1280, 512));
        send_pair(make_pair(0, 0, 16384, 2560, -512, 1280, 512, 1280));
        send_pair(make_pair(0, 0, 32768, 2560, -1280, -512, -1280, 512));
        send_pair(make_pair(0, 0, 49152, 2560, -512, -1280, 512, -1280));
        send_pair(make_pair(0, 0, 8192, 4096, 2048, 0, 0, 2048));
        // Ray ends exactly on the segment, segment endpoint on the ray
        send_pair(make_pair(0, 0, 0, 1280, 1280, -512, 1280, 512));
        send_pair(make_pair(0, 0, 0, 2560, 1280, 0, 1280, 512));
        send_pair(make_pair(0, 0, 0, 2560, 1280, -512, 1280, 0));
        // Segment through the origin: zero distance
        send_pair(make_pair(0, 0, 0, 2560, 0, -512, 0, 512));
        // Parallel, zero-length segment, zero radius
        send_pair(make_pair(0, 0, 0, 2560, 0, 256, 2560, 256));
        send_pair(make_pair(0, 0, 0, 2560, 1280, 0, 1280, 0));
        send_pair(make_pair(0, 0, 0, 0, 1280, -512, 1280, 512));
        // Misses: short ray, segment behind
        send_pair(make_pair(0, 0, 0, 1000, 1280, -512, 1280, 512));
        send_pair(make_pair(0, 0, 32768, 2560, 1280, -512, 1280, 512));
        // Field extremes
        send_pair(make_pair(8388607, 8388607, 65535, 8388607,
                            -8388608, -8388608, 8388607, -8388608));
        send_pair(make_pair(-8388608, -8388608, 32767, 8388607,
                            8388607, -8388608, -8388608, 8388607));
        send_pair(make_pair(-8388608, 8388607, 40000, 8388607,
                            8388607, 8388607, -8388608, -8388608));
        send_pair(make_pair(0, 0, 65535, 8388607, 8388607, -8388608, 8388607, 8388607));

        // Random part: bursts with random gaps between them
        for (int n = 0; n < 1550; ) begin
            burst = $urandom_range(1, 40);
            gap   = $urandom_range(0, 12);
            for (int k = 0; k < burst && n < 1550; k++, n++) begin
                t = random_pair();
                if (k == burst - 1 || n == 1549) begin
                    send_pair_then_gap(t, gap);
                end else begin
                    send_pair(t);
                end
            end
        end
        s_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Drain, then give the verdict
    initial begin
        wait (stimulus_done);
        while (board.pending_hits.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (board.fail_count == 0 && board.pending_hits.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Timeout
    initial begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
